// ===== rtl/pole_pkg.sv =====
`default_nettype none
package pole_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_FIND   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_REJECT   = 2'd1,
        STS_NOTFOUND = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_EVAL
    } t_state;

    typedef struct packed {
        logic ins;
        logic rem;
        logic sample;
    } t_cell_ctl;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned POS_W   = 7;

endpackage
`default_nettype wire

// ===== rtl/pole_cell.sv =====
`default_nettype none
module pole_cell
    import pole_pkg::*;
#(
    parameter int unsigned IDX = 0,
    parameter int unsigned IW  = 6,
    parameter int unsigned CW  = 7
) (
    input  wire logic               i_clk,
    input  wire t_cell_ctl          i_ctl,
    input  wire logic [IW-1:0]      i_pos,
    input  wire logic [CW-1:0]      i_count,
    input  wire logic [VALUE_W-1:0] i_data,
    input  wire logic [VALUE_W-1:0] i_left,
    input  wire logic [VALUE_W-1:0] i_right,
    output logic      [VALUE_W-1:0] o_value,
    output logic                    o_hit,
    output logic                    o_rsel
);

    logic [VALUE_W-1:0] r_value;
    logic [VALUE_W-1:0] n_value;
    logic               r_hit;
    logic               r_rsel;
    logic               w_valid;
    logic               w_at;
    logic               w_above;

    assign w_at    = (IW'(IDX) == i_pos);
    assign w_above = (IW'(IDX) > i_pos);
    assign w_valid = (CW'(IDX) < i_count);

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins) begin
            if (w_at) begin
                n_value = i_data;
            end else if (w_above) begin
                n_value = i_left;
            end
        end else if (i_ctl.rem) begin
            if (w_at || w_above) begin
                n_value = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (i_ctl.sample) begin
            r_hit  <= w_valid && (r_value == i_data);
            r_rsel <= w_at;
        end
    end

    assign o_value = r_value;
    assign o_hit   = r_hit;
    assign o_rsel  = r_rsel;

endmodule
`default_nettype wire

// ===== rtl/pole_reduce.sv =====
`default_nettype none
module pole_reduce
    import pole_pkg::*;
#(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned IW    = 6
) (
    input  wire logic [DEPTH-1:0]              i_hit,
    input  wire logic [DEPTH-1:0]              i_rsel,
    input  wire logic [DEPTH-1:0][VALUE_W-1:0] i_value,
    output logic                               o_found,
    output logic      [IW-1:0]                 o_first,
    output logic      [VALUE_W-1:0]            o_rd_value
);

    logic [DEPTH-1:0] w_first_hot;

    // isolate lowest set hit
    assign w_first_hot = i_hit & ~(i_hit - DEPTH'(1));
    assign o_found     = |i_hit;

    always_comb begin
        o_first    = '0;
        o_rd_value = '0;
        for (int i = 0; i < DEPTH; i++) begin
            o_first    = o_first | (IW'(i) & {IW{w_first_hot[i]}});
            o_rd_value = o_rd_value | (i_value[i] & {VALUE_W{i_rsel[i]}});
        end
    end

endmodule
`default_nettype wire

// ===== rtl/positional_ordered_list_engine_unit.sv =====
`default_nettype none
// Ordered list of up to DEPTH signed 32-bit values addressed by 1-based position,
// held in a chain of cells that shift up on insert and down on remove. Opcodes in
// s_axis_tuser: insert, remove, read, find. For each transaction the accept cycle
// updates the chain and registers per-cell compare and select flags; ST_EVAL then,
// once the output register is free, reduces those flags (first-match encoder, read
// mux) into the result register. One result per transaction, with status in m_axis_tuser
// and occupancy after the operation. A new transaction is taken while a result waits.
module positional_ordered_list_engine_unit
    import pole_pkg::*;
#(
    parameter int unsigned DEPTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // position[6:0], data_value[38:7]
    input  wire logic [1:0]  s_axis_tuser,  // opcode[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [47:0] m_axis_tdata,  // read_value[31:0], found_position[38:32],
                                            // occupancy[45:39]
    output logic      [1:0]  m_axis_tuser   // status[1:0]
);

    localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned EW = ((CW > POS_W) ? CW : POS_W) + 1;

    t_state              r_state;
    t_state              n_state;
    logic                w_accept;
    logic                w_load_out;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    t_opcode             r_op;
    logic                r_rej;
    logic [POS_W-1:0]    r_occ;
    logic                r_m_valid;
    logic [1:0]          r_status;
    logic [VALUE_W-1:0]  r_rd_value;
    logic [POS_W-1:0]    r_fpos;
    logic [POS_W-1:0]    r_m_occ;

    t_opcode             w_op;
    logic [POS_W-1:0]    w_position;
    logic [VALUE_W-1:0]  w_data;
    logic [EW-1:0]       w_pos_e;
    logic [EW-1:0]       w_cnt_e;
    logic [IW-1:0]       w_pos0;
    logic                w_ins_ok;
    logic                w_rd_ok;
    logic                w_rej;
    t_cell_ctl           w_ctl;

    logic [DEPTH-1:0]              w_hit;
    logic [DEPTH-1:0]              w_rsel;
    logic [DEPTH-1:0][VALUE_W-1:0] w_value;
    logic                          w_found;
    logic [IW-1:0]                 w_first;
    logic [VALUE_W-1:0]            w_rd_value;
    logic [IW+POS_W:0]             w_fpos_wide;

    logic [1:0]          n_status;
    logic [VALUE_W-1:0]  n_rd_value;
    logic [POS_W-1:0]    n_fpos;

    assign w_op       = t_opcode'(s_axis_tuser);
    assign w_position = s_axis_tdata[POS_W-1:0];
    assign w_data     = s_axis_tdata[POS_W+VALUE_W-1:POS_W];
    assign w_accept   = s_axis_tvalid && s_axis_tready;

    assign w_pos_e  = EW'(w_position);
    assign w_cnt_e  = EW'(r_count);
    assign w_pos0   = IW'(w_pos_e - EW'(1));
    assign w_ins_ok = (w_pos_e != '0) && (w_pos_e <= w_cnt_e + EW'(1))
                      && (w_cnt_e < EW'(DEPTH));
    assign w_rd_ok  = (w_pos_e != '0) && (w_pos_e <= w_cnt_e);

    always_comb begin
        case (w_op) inside
            OP_INSERT: w_rej = !w_ins_ok;
            OP_REMOVE, OP_READ: w_rej = !w_rd_ok;
            default: w_rej = 1'b0;
        endcase
    end

    assign w_ctl.ins    = w_accept && (w_op == OP_INSERT) && w_ins_ok;
    assign w_ctl.rem    = w_accept && (w_op == OP_REMOVE) && w_rd_ok;
    assign w_ctl.sample = w_accept;

    always_comb begin
        n_count = r_count;
        if (w_ctl.ins) begin
            n_count = r_count + CW'(1);
        end else if (w_ctl.rem) begin
            n_count = r_count - CW'(1);
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VALUE_W-1:0] w_left;
        logic [VALUE_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid
            assign w_left = w_value[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_next
            assign w_right = w_value[g+1];
        end
        pole_cell #(
            .IDX (g),
            .IW  (IW),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_pos   (w_pos0),
            .i_count (r_count),
            .i_data  (w_data),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_value[g]),
            .o_hit   (w_hit[g]),
            .o_rsel  (w_rsel[g])
        );
    end

    pole_reduce #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_reduce (
        .i_hit      (w_hit),
        .i_rsel     (w_rsel),
        .i_value    (w_value),
        .o_found    (w_found),
        .o_first    (w_first),
        .o_rd_value (w_rd_value)
    );

    assign w_fpos_wide = (IW+POS_W+1)'(w_first) + (IW+POS_W+1)'(1);

    always_comb begin
        n_status   = STS_OK;
        n_rd_value = '0;
        n_fpos     = '0;
        unique case (r_op) inside
            OP_INSERT, OP_REMOVE: begin
                n_status = r_rej ? STS_REJECT : STS_OK;
            end
            OP_READ: begin
                if (r_rej) begin
                    n_status = STS_REJECT;
                end else begin
                    n_rd_value = w_rd_value;
                end
            end
            OP_FIND: begin
                if (w_found) begin
                    n_fpos = w_fpos_wide[POS_W-1:0];
                end else begin
                    n_status = STS_NOTFOUND;
                end
            end
            default: begin
                n_status = STS_OK;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        w_load_out    = 1'b0;
        unique case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_EVAL: w_load_out = !r_m_valid || m_axis_tready;
            default: s_axis_tready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load_out) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= w_op;
            r_rej <= w_rej;
            r_occ <= POS_W'(n_count);
        end
        if (w_load_out) begin
            r_status   <= n_status;
            r_rd_value <= n_rd_value;
            r_fpos     <= n_fpos;
            r_m_occ    <= r_occ;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {2'b00, r_m_occ, r_fpos, r_rd_value};

endmodule
`default_nettype wire

// ===== dv/positional_ordered_list_engine_unit_tb.sv =====
`timescale 1ns / 100ps

module positional_ordered_list_engine_unit_tb;
    import pole_pkg::*;

    localparam int unsigned LIST_DEPTH = 64;
    localparam int unsigned N_RANDOM = 1250;
    localparam logic [31:0] VALUE_POOL [8] = '{
        32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
        32'h0000_0001, 32'h5a5a_5a5a, 32'ha5a5_a5a5, 32'h0001_0000
    };

    typedef struct {
        t_opcode     op;
        logic [6:0]  pos;
        logic [31:0] val;
    } t_list_op;

    typedef struct {
        t_status     status;
        logic [31:0] read_value;
        logic [6:0]  found_pos;
        logic [6:0]  occupancy;
    } t_list_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;  // position[6:0], data_value[38:7]
    logic [1:0]  s_axis_tuser = '0;  // opcode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [47:0] m_axis_tdata;       // read_value[31:0], found_position[38:32],
                                     // occupancy[45:39]
    logic [1:0]  m_axis_tuser;       // status[1:0]

    positional_ordered_list_engine_unit #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    t_list_op     pending_ops[$];
    t_list_result expected_results[$];
    logic [31:0]  list_vals[$];
    t_list_op     cur_op;
    bit           offering = 1'b0;
    bit           calm = 1'b0;
    bit           next_ready;
    int           send_gap = 0;
    int           recv_gap = 0;
    int           n_errors = 0;
    int           n_accepted = 0;
    int           n_results = 0;
    int           n_rejects = 0;
    int           n_not_found = 0;
    int           n_full_inserts = 0;
    int           peak_count = 0;

    function automatic t_list_result apply_list_op(t_list_op item);
        t_list_result res;
        int           cnt;
        int           p;
        cnt = list_vals.size();
        p = int'(item.pos);
        res.status = STS_OK;
        res.read_value = '0;
        res.found_pos = '0;
        case (item.op)
            OP_INSERT: begin
                if (cnt >= LIST_DEPTH) n_full_inserts++;
                if (p < 1 || p > cnt + 1 || cnt >= LIST_DEPTH) res.status = STS_REJECT;
                else list_vals.insert(p - 1, item.val);
            end
            OP_REMOVE: begin
                if (p < 1 || p > cnt) res.status = STS_REJECT;
                else list_vals.delete(p - 1);
            end
            OP_READ: begin
                if (p < 1 || p > cnt) res.status = STS_REJECT;
                else res.read_value = list_vals[p - 1];
            end
            default: begin
                res.status = STS_NOTFOUND;
                for (int i = 0; i < cnt; i++) begin
                    if (list_vals[i] == item.val) begin
                        res.status = STS_OK;
                        res.found_pos = 7'(i + 1);
                        break;
                    end
                end
            end
        endcase
        res.occupancy = 7'(list_vals.size());
        if (list_vals.size() > peak_count) peak_count = list_vals.size();
        return res;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            offering = 1'b0;
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(apply_list_op(cur_op));
                n_accepted++;
                offering = 1'b0;
            end
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_ops.size() > 0) begin
                    if (!calm && $urandom_range(0, 99) < 8) begin
                        send_gap = $urandom_range(1, 13);
                    end else begin
                        cur_op = pending_ops.pop_front();
                        offering = 1'b1;
                        s_axis_tdata <= {1'b0, cur_op.val, cur_op.pos};
                        s_axis_tuser <= cur_op.op;
                    end
                end
            end
            s_axis_tvalid <= offering;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_list_result exp_res;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result transaction: expected none, actual %h/%h",
                             $time, m_axis_tuser, m_axis_tdata);
                    n_errors++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (exp_res.status == STS_REJECT) n_rejects++;
                    if (exp_res.status == STS_NOTFOUND) n_not_found++;
                    if (m_axis_tuser != exp_res.status) begin
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, exp_res.status, m_axis_tuser);
                        n_errors++;
                    end
                    if (m_axis_tdata[31:0] != exp_res.read_value) begin
                        $display("%0t: read_value mismatch: expected %h actual %h",
                                 $time, exp_res.read_value, m_axis_tdata[31:0]);
                        n_errors++;
                    end
                    if (m_axis_tdata[38:32] != exp_res.found_pos) begin
                        $display("%0t: found_position mismatch: expected %0d actual %0d",
                                 $time, exp_res.found_pos, m_axis_tdata[38:32]);
                        n_errors++;
                    end
                    if (m_axis_tdata[45:39] != exp_res.occupancy) begin
                        $display("%0t: occupancy mismatch: expected %0d actual %0d",
                                 $time, exp_res.occupancy, m_axis_tdata[45:39]);
                        n_errors++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                next_ready = (recv_gap == 0);
            end else if (!calm && $urandom_range(0, 99) < 8) begin
                recv_gap = $urandom_range(1, 13);
                next_ready = 1'b0;
            end else begin
                next_ready = 1'b1;
            end
            m_axis_tready <= next_ready;
        end
    end

    task automatic push_op(t_opcode op, logic [6:0] pos, logic [31:0] val);
        t_list_op item;
        item.op = op;
        item.pos = pos;
        item.val = val;
        pending_ops.push_back(item);
    endtask

    task automatic wait_drained();
        while (pending_ops.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic run_phase(int n, int w_ins, int w_rem, int w_rd);
        int          r;
        int          est;
        t_opcode     op;
        logic [6:0]  pos;
        logic [31:0] val;
        for (int k = 0; k < n; k++) begin
            while (pending_ops.size() != 0) @(negedge i_clk);
            est = list_vals.size();
            r = $urandom_range(0, 99);
            if (r < w_ins) op = OP_INSERT;
            else if (r < w_ins + w_rem) op = OP_REMOVE;
            else if (r < w_ins + w_rem + w_rd) op = OP_READ;
            else op = OP_FIND;
            r = $urandom_range(0, 99);
            if (op == OP_FIND || r < 10) begin
                pos = 7'($urandom_range(0, 127));
            end else if (r < 16) begin
                case ($urandom_range(0, 4))
                    0: pos = 7'd0;
                    1: pos = 7'(est);
                    2: pos = 7'(est + 1);
                    3: pos = 7'(LIST_DEPTH);
                    default: pos = 7'(LIST_DEPTH + 1);
                endcase
            end else if (op == OP_INSERT) begin
                pos = 7'($urandom_range(1, est + 1));
            end else begin
                pos = 7'($urandom_range(1, (est > 0) ? est : 1));
            end
            r = $urandom_range(0, 99);
            if (op == OP_FIND && r < 60 && list_vals.size() > 0)
                val = list_vals[$urandom_range(0, list_vals.size() - 1)];
            else if (r < 80)
                val = VALUE_POOL[$urandom_range(0, 7)];
            else
                val = $urandom;
            push_op(op, pos, val);
        end
        wait_drained();
    endtask

    initial begin
        // empty list corners
        push_op(OP_REMOVE, 7'd1, 32'h0);
        push_op(OP_READ, 7'd1, 32'h0);
        push_op(OP_FIND, 7'd0, 32'h0);
        push_op(OP_INSERT, 7'd0, 32'h1234_5678);
        push_op(OP_INSERT, 7'd2, 32'h1234_5678);
        // head, tail, middle and duplicate inserts
        push_op(OP_INSERT, 7'd1, 32'h8000_0000);
        push_op(OP_INSERT, 7'd2, 32'h7fff_ffff);
        push_op(OP_INSERT, 7'd1, 32'h0000_0000);
        push_op(OP_INSERT, 7'd2, 32'hffff_ffff);
        push_op(OP_INSERT, 7'd1, 32'h7fff_ffff);
        push_op(OP_FIND, 7'd0, 32'h7fff_ffff);
        push_op(OP_FIND, 7'd0, 32'h1234_5678);
        // out of range positions, mixed with in-range reads and removes
        push_op(OP_READ, 7'd0, 32'h0);
        push_op(OP_READ, 7'd5, 32'h0);
        push_op(OP_READ, 7'd6, 32'h0);
        push_op(OP_READ, 7'd127, 32'hffff_ffff);
        push_op(OP_REMOVE, 7'd127, 32'h0);
        push_op(OP_REMOVE, 7'd0, 32'h0);
        push_op(OP_INSERT, 7'd127, 32'hffff_ffff);
        push_op(OP_REMOVE, 7'd1, 32'h0);
        push_op(OP_FIND, 7'd127, 32'h7fff_ffff);
        push_op(OP_REMOVE, 7'd4, 32'hffff_ffff);
        push_op(OP_READ, 7'd2, 32'hffff_ffff);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_drained();
        for (int k = 0; k < 3; k++) begin
            run_phase(N_RANDOM * 12 / 100, 75, 8, 8);
            run_phase(N_RANDOM * 8 / 100, 30, 25, 20);
            run_phase(N_RANDOM * 12 / 100, 10, 70, 10);
        end
        calm = 1'b1;
        run_phase(N_RANDOM * 5 / 100, 30, 25, 20);
        wait_drained();
        repeat (10) @(negedge i_clk);
        $display("covered %0d transactions, %0d results, peak occupancy %0d of %0d",
                 n_accepted, n_results, peak_count, LIST_DEPTH);
        $display("rejected %0d, failed finds %0d, inserts into a full list %0d",
                 n_rejects, n_not_found, n_full_inserts);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("positional_ordered_list_engine_unit_tb: clean");
        end else begin
            $display("positional_ordered_list_engine_unit_tb: errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("positional_ordered_list_engine_unit_tb: errors");
        $finish;
    end

endmodule
